// ===== rtl/hsl_to_rgb_converter_assert.svh =====
// Assertion macros for the HSL to RGB converter RTL.
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define HSL_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("hsl_to_rgb assertion failed");
// Check a property on every clock edge, reset included.
`define HSL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("hsl_to_rgb assertion failed");
`else
`define HSL_ASSERT(lbl, clk, rstn, prop)
`define HSL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/hsl_pkg.sv =====
// Types, constants and the hue ramp shared by the HSL to RGB converter.
package hsl_pkg;

    localparam int HUE_W    = 9;
    localparam int LEVEL_W  = 16;
    localparam int CH_W     = 8;
    localparam int WEIGHT_W = 6;
    localparam int ANGLE_W  = 11;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    localparam logic signed [ANGLE_W-1:0] HUE_SHIFT = 11'sd120;
    localparam logic signed [ANGLE_W-1:0] HUE_FULL  = 11'sd360;
    localparam logic signed [ANGLE_W-1:0] RAMP_UP   = 11'sd60;
    localparam logic signed [ANGLE_W-1:0] RAMP_TOP  = 11'sd180;
    localparam logic signed [ANGLE_W-1:0] RAMP_END  = 11'sd240;

    localparam logic [WEIGHT_W-1:0] RAMP_FULL = 6'd60;
    localparam logic [CH_W-1:0]     CH_MAX    = 8'hFF;

    // Per-stage advance strobes of the pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } hsl_adv_t;

    // Wrap the angle once, then map it onto the 0..60 hue ramp.
    function automatic logic [WEIGHT_W-1:0] hue_weight(
        input logic signed [ANGLE_W-1:0] angle
    );
        logic signed [ANGLE_W-1:0] a;
        logic signed [ANGLE_W-1:0] d;
        logic [WEIGHT_W-1:0]       w;
        a = angle;
        if (a < 0) begin
            a = a + HUE_FULL;
        end
        if (a > HUE_FULL) begin
            a = a - HUE_FULL;
        end
        d = RAMP_END - a;
        priority if (a < RAMP_UP) begin
            w = WEIGHT_W'(a);
        end else if (a < RAMP_TOP) begin
            w = RAMP_FULL;
        end else if (a < RAMP_END) begin
            w = WEIGHT_W'(d);
        end else begin
            w = '0;
        end
        return w;
    endfunction

endpackage

// ===== rtl/hsl_level.sv =====
// Two-level stage: forms the high and low HSL levels and the grey value.
module hsl_level
    import hsl_pkg::*;
#(
    parameter int FRAC_BITS = 15,
    parameter int LW        = 35
) (
    input  logic                  aclk,
    input  hsl_adv_t              adv,
    input  logic [LEVEL_W-1:0]    saturation,
    input  logic [LEVEL_W-1:0]    lightness,
    output logic signed [LW-1:0]  level_hi,
    output logic signed [LW-1:0]  level_lo,
    output logic [CH_W-1:0]       grey,
    output logic                  grey_sel
);

    localparam logic signed [LW-1:0] ONE = LW'(1) <<< FRAC_BITS;
    localparam int GREY_W = LEVEL_W + CH_W;

    logic [LEVEL_W-1:0]     sat_reg;
    logic [LEVEL_W-1:0]     light_reg;
    logic [2*LEVEL_W-1:0]   ls_reg;

    logic signed [LW-1:0]   hi_reg, hi_next;
    logic signed [LW-1:0]   lo_reg, lo_next;
    logic [CH_W-1:0]        grey_reg, grey_next;
    logic                   sel_reg, sel_next;

    logic signed [LW-1:0]   l_ext, s_ext, ls_ext, l_one, s_one;
    logic [GREY_W-1:0]      gprod, gshift;

    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            sat_reg   <= saturation;
            light_reg <= lightness;
            ls_reg    <= saturation * lightness;
        end
    end

    always_comb begin
        l_ext  = LW'(light_reg);
        s_ext  = LW'(sat_reg);
        ls_ext = LW'(ls_reg);
        l_one  = l_ext <<< FRAC_BITS;
        s_one  = s_ext <<< FRAC_BITS;
        if ((l_ext <<< 1) < ONE) begin
            hi_next = l_one + ls_ext;
        end else begin
            hi_next = l_one + s_one - ls_ext;
        end
        lo_next = (l_one <<< 1) - hi_next;

        // grey = l * 255 / ONE, clipped to full scale
        gprod     = {light_reg, {CH_W{1'b0}}} - GREY_W'(light_reg);
        gshift    = gprod >> FRAC_BITS;
        grey_next = (|gshift[GREY_W-1:CH_W]) ? CH_MAX : gshift[CH_W-1:0];
        sel_next  = (sat_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
            grey_reg <= grey_next;
            sel_reg  <= sel_next;
        end
    end

    assign level_hi = hi_reg;
    assign level_lo = lo_reg;
    assign grey     = grey_reg;
    assign grey_sel = sel_reg;

endmodule

// ===== rtl/hsl_channel.sv =====
// One color channel: weights the two levels, scales by 255/60 and clips.
module hsl_channel
    import hsl_pkg::*;
#(
    parameter int FRAC_BITS = 15,
    parameter int LW        = 35
) (
    input  logic                  aclk,
    input  hsl_adv_t              adv,
    input  logic signed [LW-1:0]  level_hi,
    input  logic signed [LW-1:0]  level_lo,
    input  logic [WEIGHT_W-1:0]   weight,
    input  logic [CH_W-1:0]       grey,
    input  logic                  grey_sel,
    output logic [CH_W-1:0]       chan
);

    localparam int PW = LW + WEIGHT_W + 1;
    localparam int QW = PW + 6;
    localparam int SHIFT = 2 * FRAC_BITS + 2;

    logic signed [PW-1:0] pa_reg, pa_next;
    logic signed [PW-1:0] pb_reg, pb_next;
    logic [CH_W-1:0]      grey_reg;
    logic                 sel_reg;
    logic [CH_W-1:0]      chan_reg, chan_next;

    logic signed [PW-1:0] wlo, whi;
    logic signed [QW-1:0] sum, scaled, quot;

    always_comb begin
        wlo     = PW'($signed({1'b0, RAMP_FULL - weight}));
        whi     = PW'($signed({1'b0, weight}));
        pa_next = PW'(level_lo) * wlo;
        pb_next = PW'(level_hi) * whi;
    end

    always_ff @(posedge aclk) begin
        if (adv.s3) begin
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            grey_reg <= grey;
            sel_reg  <= grey_sel;
        end
    end

    // 255/60 == 17/4, so the scale is a multiply by 17 and a shift
    always_comb begin
        sum    = QW'(pa_reg) + QW'(pb_reg);
        scaled = (sum <<< 4) + sum;
        quot   = scaled >>> SHIFT;
        if (sel_reg) begin
            chan_next = grey_reg;
        end else if (sum <= 0) begin
            chan_next = '0;
        end else if (|quot[QW-1:CH_W]) begin
            chan_next = CH_MAX;
        end else begin
            chan_next = quot[CH_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.s4) begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

// ===== rtl/hsl_to_rgb_converter.sv =====
// Top level of the HSL to RGB pixel converter.
//
// Input stream s_*: one pixel per transfer, s_tdata carries hue in degrees,
// saturation and lightness (fixed point, 1 << FRAC_BITS is 1.0).
// Output stream m_*: one RGB pixel per transfer, 8 bits per channel.
// Every input transfer yields exactly one output transfer, in order.
// Throughput: one pixel per clock while m_tready is high; the four register
// stages each hold one pixel and an item can enter every cycle while s_tready is high.
// The result is registered through the stages product l*s, levels,
// weighted products and scale before it is presented on m_tdata.
// Reset (aresetn low, synchronous) empties all stages; no output is shown.
// When m_tready is low the last stage holds its result; earlier stages
// keep advancing into empty slots, so s_tready drops only once every
// stage holds a pixel.
module hsl_to_rgb_converter
    import hsl_pkg::*;
#(
    parameter int FRAC_BITS = 15
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [8:0] hue_degrees, [24:9] saturation, [40:25] lightness, [47:41] zero
    input  logic [S_TDATA_W-1:0] s_tdata,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [M_TDATA_W-1:0] m_tdata
);

`include "hsl_to_rgb_converter_assert.svh"

    localparam int LW = ((FRAC_BITS > 15) ? FRAC_BITS : 15) + 20;
    localparam int NUM_CH = 3;

    logic [HUE_W-1:0]   hue_in;
    logic [LEVEL_W-1:0] sat_in;
    logic [LEVEL_W-1:0] light_in;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    hsl_adv_t adv;

    logic [WEIGHT_W-1:0] w1_reg [NUM_CH];
    logic [WEIGHT_W-1:0] w2_reg [NUM_CH];
    logic [WEIGHT_W-1:0] w_next [NUM_CH];
    logic signed [ANGLE_W-1:0] hue_ext;

    logic signed [LW-1:0] level_hi, level_lo;
    logic [CH_W-1:0]      grey;
    logic                 grey_sel;
    logic [CH_W-1:0]      chan [NUM_CH];

    assign hue_in   = s_tdata[HUE_W-1:0];
    assign sat_in   = s_tdata[HUE_W +: LEVEL_W];
    assign light_in = s_tdata[HUE_W+LEVEL_W +: LEVEL_W];

    // A stage may load when it is empty or its content moves on.
    always_comb begin
        rdy4   = !v4_reg || m_tready;
        rdy3   = !v3_reg || rdy4;
        rdy2   = !v2_reg || rdy3;
        rdy1   = !v1_reg || rdy2;
        adv.s1 = rdy1;
        adv.s2 = rdy2;
        adv.s3 = rdy3;
        adv.s4 = rdy4;
    end

    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Red leads by a third of a turn, blue lags by a third.
    always_comb begin
        hue_ext   = $signed({2'b00, hue_in});
        w_next[0] = hue_weight(hue_ext + HUE_SHIFT);
        w_next[1] = hue_weight(hue_ext);
        w_next[2] = hue_weight(hue_ext - HUE_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (adv.s1) w1_reg <= w_next;
        if (adv.s2) w2_reg <= w1_reg;
    end

    hsl_level #(
        .FRAC_BITS (FRAC_BITS),
        .LW        (LW)
    ) u_level (
        .aclk       (aclk),
        .adv        (adv),
        .saturation (sat_in),
        .lightness  (light_in),
        .level_hi   (level_hi),
        .level_lo   (level_lo),
        .grey       (grey),
        .grey_sel   (grey_sel)
    );

    for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
        hsl_channel #(
            .FRAC_BITS (FRAC_BITS),
            .LW        (LW)
        ) u_chan (
            .aclk     (aclk),
            .adv      (adv),
            .level_hi (level_hi),
            .level_lo (level_lo),
            .weight   (w2_reg[c]),
            .grey     (grey),
            .grey_sel (grey_sel),
            .chan     (chan[c])
        );
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {chan[2], chan[1], chan[0]};

    `HSL_ASSERT(a_accept_fills_s1, aclk, aresetn, (s_tvalid && s_tready) |=> v1_reg)
    `HSL_ASSERT(a_empty_s1_ready, aclk, aresetn, (!v1_reg) |-> s_tready)
    `HSL_ASSERT(a_s2_held, aclk, aresetn, (v2_reg && !rdy3) |=> v2_reg)
    `HSL_ASSERT(a_s1_moves, aclk, aresetn, (v1_reg && rdy2) |=> v2_reg)

endmodule

// ===== verif/hsl_to_rgb_converter_checker.sv =====
// Checker that predicts each RGB pixel from its HSL input and compares it with the output stream.
module hsl_to_rgb_converter_checker
    import hsl_pkg::*;
#(
    parameter int FRAC_BITS = 15
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   error_count,
    output int                   pending_pixels
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE = longint'(1) << FRAC_BITS;

    // Packed structs put the first member highest, so blue, the highest field in m_tdata, is declared first.
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgb_pixel_t;

    rgb_pixel_t rgb_expected[$];

    initial begin
        error_count    = 0;
        pending_pixels = 0;
    end

    // Wrap once, then map onto the 0..60 hue ramp.
    function automatic longint ramp_weight(input longint angle);
        longint a;
        a = angle;
        if (a < 0) begin
            a = a + 360;
        end
        if (a > 360) begin
            a = a - 360;
        end
        if (a < 60) begin
            return a;
        end else if (a < 180) begin
            return 60;
        end else if (a < 240) begin
            return 240 - a;
        end
        return 0;
    endfunction

    function automatic logic [CH_W-1:0] channel_level(input longint lo, input longint hi,
                                                      input longint angle);
        longint num;
        longint q;
        num = 60 * lo + (hi - lo) * ramp_weight(angle);
        if (num <= 0) begin
            return '0;
        end
        q = (num * 255) / (60 * ONE * ONE);
        if (q > 255) begin
            q = 255;
        end
        return CH_W'(q);
    endfunction

    function automatic rgb_pixel_t predict_rgb(input logic [HUE_W-1:0] hue,
                                               input logic [LEVEL_W-1:0] sat,
                                               input logic [LEVEL_W-1:0] lit);
        longint h;
        longint s;
        longint l;
        longint hi;
        longint lo;
        longint g;
        rgb_pixel_t px;
        h = longint'(hue);
        s = longint'(sat);
        l = longint'(lit);
        if (s == 0) begin
            // Grey: all three channels at the scaled lightness.
            g = (l * 255) / ONE;
            if (g > 255) begin
                g = 255;
            end
            px.red   = CH_W'(g);
            px.green = CH_W'(g);
            px.blue  = CH_W'(g);
            return px;
        end
        if (2 * l < ONE) begin
            hi = l * (ONE + s);
        end else begin
            hi = (l + s) * ONE - l * s;
        end
        lo = 2 * l * ONE - hi;
        px.red   = channel_level(lo, hi, h + 120);
        px.green = channel_level(lo, hi, h);
        px.blue  = channel_level(lo, hi, h - 120);
        return px;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge aclk) begin
        rgb_pixel_t got;
        rgb_pixel_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                rgb_expected.push_back(predict_rgb(s_tdata[HUE_W-1:0],
                                                   s_tdata[HUE_W +: LEVEL_W],
                                                   s_tdata[HUE_W+LEVEL_W +: LEVEL_W]));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (rgb_expected.size() == 0) begin
                    report_mismatch($sformatf("output transfer 0x%06h with no pixel pending",
                                              m_tdata));
                end else begin
                    want = rgb_expected.pop_front();
                    if (got.red !== want.red) begin
                        report_mismatch($sformatf("red got %0d expected %0d",
                                                  got.red, want.red));
                    end
                    if (got.green !== want.green) begin
                        report_mismatch($sformatf("green got %0d expected %0d",
                                                  got.green, want.green));
                    end
                    if (got.blue !== want.blue) begin
                        report_mismatch($sformatf("blue got %0d expected %0d",
                                                  got.blue, want.blue));
                    end
                end
            end
        end
        pending_pixels <= rgb_expected.size();
    end

endmodule

// ===== verif/hsl_to_rgb_converter_test.sv =====
// Top of the HSL to RGB converter testbench: clock, reset, pixel stimulus and verdict.
module hsl_to_rgb_converter_test
    import hsl_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS      = 15;
    localparam int ONE            = 1 << FRAC_BITS;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int error_count;
    int pending_pixels;
    bit idle_on      = 1'b1;
    int ready_stall  = 0;
    int stuck_cycles = 0;

    always #5 aclk = ~aclk;

    hsl_to_rgb_converter #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    hsl_to_rgb_converter_checker #(
        .FRAC_BITS(FRAC_BITS)
    ) pixel_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .error_count   (error_count),
        .pending_pixels(pending_pixels)
    );

    // Output back-pressure in random bursts while idle_on is set.
    always @(posedge aclk) begin
        if (ready_stall > 0) begin
            ready_stall <= ready_stall - 1;
            m_tready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            ready_stall <= $urandom_range(0, 10);
            m_tready    <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    // Present one pixel and hold it until the transfer completes.
    task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [LEVEL_W-1:0] sat,
                              input logic [LEVEL_W-1:0] lit);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-HUE_W-2*LEVEL_W){1'b0}}, lit, sat, hue};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [LEVEL_W-1:0] random_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return LEVEL_W'(ONE);
            2:       return LEVEL_W'($urandom_range(0, 65535));
            default: return LEVEL_W'($urandom_range(0, ONE));
        endcase
    endfunction

    task automatic send_random_pixels(input int count);
        logic [HUE_W-1:0] hue;
        for (int i = 0; i < count; i++) begin
            // Mostly valid angles, some above a full turn.
            if ($urandom_range(0, 99) < 85) begin
                hue = HUE_W'($urandom_range(0, 359));
            end else begin
                hue = HUE_W'($urandom_range(0, 511));
            end
            send_pixel(hue, random_level(), random_level());
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Grey, including lightness past 1.0.
        send_pixel(0, 0, 0);
        send_pixel(0, 0, LEVEL_W'(ONE));
        send_pixel(0, 0, 16'hFFFF);
        send_pixel(0, 0, LEVEL_W'(ONE / 2));
        // Primaries, secondaries and ramp corners.
        send_pixel(0, LEVEL_W'(ONE), LEVEL_W'(ONE / 2));
        send_pixel(120, LEVEL_W'(ONE), LEVEL_W'(ONE / 2));
        send_pixel(240, LEVEL_W'(ONE), LEVEL_W'(ONE / 2));
        send_pixel(60, LEVEL_W'(ONE), LEVEL_W'(ONE / 2));
        send_pixel(180, LEVEL_W'(ONE), LEVEL_W'(ONE / 2));
        send_pixel(300, LEVEL_W'(ONE), LEVEL_W'(ONE / 4));
        send_pixel(359, LEVEL_W'(ONE), LEVEL_W'(ONE));
        // Over-range levels: negative low level and clipping at the top.
        send_pixel(359, 16'hFFFF, 16'hFFFF);
        send_pixel(30, 16'hFFFF, LEVEL_W'(ONE / 2));
        send_pixel(90, LEVEL_W'(ONE), 16'hFFFF);
        // Lightness just below half takes the other level formula.
        send_pixel(200, LEVEL_W'(ONE / 2), LEVEL_W'(ONE / 2 - 1));
        // Angles of a full turn and beyond wrap only once.
        send_pixel(360, LEVEL_W'(ONE), LEVEL_W'(ONE / 2));
        send_pixel(480, LEVEL_W'(ONE), LEVEL_W'(ONE / 2));
        send_pixel(511, 12345, 20000);
        send_pixel(150, 1, 1);
        send_pixel(255, LEVEL_W'(ONE / 3), LEVEL_W'(3 * ONE / 4));

        send_random_pixels(480);
        idle_on <= 1'b0;
        send_random_pixels(150);
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (pending_pixels != 0);
        repeat (6) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
